// ===== hw/rtl/ssdf_pkg.sv =====
// Shared types, constants, font table and helper functions of the seven-segment formatter.
package ssdf_pkg;

    localparam int CUR_W  = 2;
    localparam int ADDR_W = 6;
    localparam int SEG_W  = 8;
    localparam int CODE_W = 8;
    localparam int NUM_W  = 16;
    localparam int BCD_W  = 4;

    localparam logic [ADDR_W-1:0] DIGIT_BASE = 6'h34;
    localparam logic [CODE_W-1:0] CR_CODE    = 8'd13;
    localparam logic [CODE_W-1:0] FONT_FIRST = 8'd32;
    localparam int                FONT_SIZE  = 96;
    localparam logic [CODE_W-1:0] ASCII_ZERO = 8'd48;
    localparam logic [SEG_W-1:0]  DP_ADD     = 8'h80;

    // floor(x / 10) == (x * 52429) >> 19 for every 16-bit x
    localparam logic [16:0] DIV10_MUL   = 17'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef enum logic {
        OP_CHAR   = 1'b0,
        OP_NUMBER = 1'b1
    } op_t;

    // Request fields carried down the digit pipeline
    typedef struct packed {
        op_t               op;
        logic [CODE_W-1:0] char_code;
        logic              dp;
        logic [CUR_W-1:0]  pos;
    } req_t;

    // Font for codes 32..127
    localparam logic [SEG_W-1:0] FONT [FONT_SIZE] = '{
        8'h00, 8'h82, 8'h21, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02,
        8'h39, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h40, 8'h80, 8'h00,
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h48, 8'h00, 8'h53,
        8'h00, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h6F,
        8'h76, 8'h06, 8'h1E, 8'h00, 8'h38, 8'h00, 8'h54, 8'h3F,
        8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h3E, 8'h00, 8'h00,
        8'h00, 8'h6E, 8'h00, 8'h39, 8'h00, 8'h0F, 8'h00, 8'h08,
        8'h63, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F,
        8'h74, 8'h02, 8'h1E, 8'h00, 8'h06, 8'h00, 8'h54, 8'h5C,
        8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h00, 8'h00,
        8'h00, 8'h6E, 8'h00, 8'h39, 8'h30, 8'h0F, 8'h00, 8'h00
    };

    // Codes outside the printable range come out blank
    function automatic logic [SEG_W-1:0] font_lookup(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] offs;
        begin
            offs = code - FONT_FIRST;
            if (code < FONT_FIRST || code[7]) begin
                return '0;
            end
            return FONT[offs[6:0]];
        end
    endfunction

    function automatic logic [NUM_W-1:0] div10(input logic [NUM_W-1:0] val);
        logic [32:0] prod;
        begin
            prod = 33'(val) * 33'(DIV10_MUL);
            return NUM_W'(prod >> DIV10_SHIFT);
        end
    endfunction

endpackage

// ===== hw/rtl/ssdf_digit_pipe.sv =====
// Input register and decimal digit extraction pipeline, one digit per stage.
module ssdf_digit_pipe #(
    parameter int NUM_DIGITS = 4
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           advance,
    input  logic                                           in_valid,
    input  ssdf_pkg::req_t                                 in_req,
    input  logic [ssdf_pkg::NUM_W-1:0]                     in_number,
    output logic                                           out_valid,
    output ssdf_pkg::req_t                                 out_req,
    output logic [NUM_DIGITS-1:0][ssdf_pkg::BCD_W-1:0]     out_digits
);

    localparam int BW = ssdf_pkg::BCD_W;
    localparam int NW = ssdf_pkg::NUM_W;

    // Stage 0 is the input register, stage k+1 holds digit k (least significant first)
    logic                              valid_reg [NUM_DIGITS+1];
    ssdf_pkg::req_t                    req_reg   [NUM_DIGITS+1];
    logic [NW-1:0]                     q_reg     [NUM_DIGITS+1];
    logic [NUM_DIGITS-1:0][BW-1:0]     dig_reg   [NUM_DIGITS+1];

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (advance) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            req_reg[0] <= in_req;
            q_reg[0]   <= in_number;
            dig_reg[0] <= '0;
        end
    end

    // Each stage peels one decimal digit off the running quotient
    for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_stage
        logic [NW-1:0]                 quo;
        logic [NW-1:0]                 quo_x10;
        logic [BW-1:0]                 digit;
        logic [NUM_DIGITS-1:0][BW-1:0] dig_next;

        assign quo     = ssdf_pkg::div10(q_reg[k]);
        assign quo_x10 = (quo << 3) + (quo << 1);
        assign digit   = BW'(q_reg[k] - quo_x10);

        always_comb begin
            dig_next    = dig_reg[k];
            dig_next[k] = digit;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (advance) begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                req_reg[k+1] <= req_reg[k];
                q_reg[k+1]   <= quo;
                dig_reg[k+1] <= dig_next;
            end
        end
    end

    assign out_valid  = valid_reg[NUM_DIGITS];
    assign out_req    = req_reg[NUM_DIGITS];
    assign out_digits = dig_reg[NUM_DIGITS];

endmodule

// ===== hw/rtl/seven_segment_display_formatter.sv =====
// Seven-segment formatter: turns character and number requests into digit-register writes.
//
// Input channel (s_*): one request per valid/ready handshake. s_op selects character
// mode (one write of the font pattern of s_char_code at the cursor, plus the decimal
// point when s_dp is set) or number mode (NUM_DIGITS writes of s_number modulo
// 10^NUM_DIGITS, most significant digit first, at positions 0 upward).
// A carriage return in character mode only homes the cursor and produces no write.
// Result channel (m_*): one digit-register write per handshake; m_last marks the
// final write of a request.
// Path: an accepted request passes the input register, one pipeline stage per decimal
// digit and the output register before its first write is valid.
// Rate: the single output register emits one write per cycle while m_ready is high.
// Stall: while a write waits on m_ready, or a number request has writes left to emit,
// the whole pipeline and s_ready hold; the next request is taken in the same cycle the
// final write of the current one is taken.
// Reset (aresetn low, synchronous): pipeline and output emptied, cursor returns to 0.
module seven_segment_display_formatter #(
    parameter int NUM_DIGITS = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic [ssdf_pkg::CODE_W-1:0]       s_char_code,
    input  logic                              s_dp,
    input  logic [ssdf_pkg::NUM_W-1:0]        s_number,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ssdf_pkg::ADDR_W-1:0]       m_digit_address,
    output logic [ssdf_pkg::SEG_W-1:0]        m_segments,
    output logic                              m_last
);

    localparam int CW    = ssdf_pkg::CUR_W;
    localparam int AW    = ssdf_pkg::ADDR_W;
    localparam int BW    = ssdf_pkg::BCD_W;
    localparam int DIG_W = NUM_DIGITS * BW;

    logic                          advance;
    logic                          accept;
    logic                          is_cr;
    logic [CW-1:0]                 cursor_reg;
    logic [CW-1:0]                 cursor_next;
    ssdf_pkg::req_t                in_req;
    logic                          pipe_valid;
    ssdf_pkg::req_t                pipe_req;
    logic [NUM_DIGITS-1:0][BW-1:0] pipe_digits;
    logic [DIG_W-1:0]              pipe_digits_flat;

    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic [AW-1:0]                 m_digit_address_reg;
    logic [AW-1:0]                 m_digit_address_next;
    logic [ssdf_pkg::SEG_W-1:0]    m_segments_reg;
    logic [ssdf_pkg::SEG_W-1:0]    m_segments_next;
    logic                          m_last_reg;
    logic                          m_last_next;
    logic [CW-1:0]                 idx_reg;
    logic [CW-1:0]                 idx_next;
    logic [DIG_W-1:0]              rem_reg;
    logic [DIG_W-1:0]              rem_next;

    // Whole pipeline moves when the output register is free or releases its final write
    assign advance = !m_valid_reg || (m_ready && m_last_reg);
    assign s_ready = advance;
    assign accept  = s_valid && advance;
    assign is_cr   = (ssdf_pkg::op_t'(s_op) == ssdf_pkg::OP_CHAR)
                     && (s_char_code == ssdf_pkg::CR_CODE);

    // Cursor tracks character requests in acceptance order
    always_comb begin
        cursor_next = cursor_reg;
        if (accept && ssdf_pkg::op_t'(s_op) == ssdf_pkg::OP_CHAR) begin
            if (is_cr || cursor_reg == CW'(NUM_DIGITS - 1)) begin
                cursor_next = '0;
            end else begin
                cursor_next = cursor_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
        end else begin
            cursor_reg <= cursor_next;
        end
    end

    always_comb begin
        in_req.op        = ssdf_pkg::op_t'(s_op);
        in_req.char_code = s_char_code;
        in_req.dp        = s_dp;
        in_req.pos       = cursor_reg;
    end

    // Carriage return is consumed here and never enters the pipeline
    ssdf_digit_pipe #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_digit_pipe (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .in_valid   (accept && !is_cr),
        .in_req     (in_req),
        .in_number  (s_number),
        .out_valid  (pipe_valid),
        .out_req    (pipe_req),
        .out_digits (pipe_digits)
    );

    assign pipe_digits_flat = pipe_digits;

    // Output register: loads a new request or steps through the remaining digits
    always_comb begin
        m_valid_next         = m_valid_reg;
        m_digit_address_next = m_digit_address_reg;
        m_segments_next      = m_segments_reg;
        m_last_next          = m_last_reg;
        idx_next             = idx_reg;
        rem_next             = rem_reg;
        if (advance) begin
            m_valid_next = pipe_valid;
            idx_next     = '0;
            if (pipe_req.op == ssdf_pkg::OP_CHAR) begin
                m_digit_address_next = ssdf_pkg::DIGIT_BASE + AW'(pipe_req.pos);
                m_segments_next      = ssdf_pkg::font_lookup(pipe_req.char_code)
                                       + (pipe_req.dp ? ssdf_pkg::DP_ADD : 8'd0);
                m_last_next          = 1'b1;
                rem_next             = '0;
            end else begin
                m_digit_address_next = ssdf_pkg::DIGIT_BASE;
                m_segments_next      = ssdf_pkg::font_lookup(ssdf_pkg::ASCII_ZERO
                                       + 8'(pipe_digits[NUM_DIGITS-1]));
                m_last_next          = (NUM_DIGITS == 1);
                rem_next             = pipe_digits_flat << BW;
            end
        end else if (m_valid_reg && m_ready) begin
            idx_next             = idx_reg + CW'(1);
            m_digit_address_next = ssdf_pkg::DIGIT_BASE + AW'(idx_next);
            m_segments_next      = ssdf_pkg::font_lookup(ssdf_pkg::ASCII_ZERO
                                   + 8'(rem_reg[DIG_W-1 -: BW]));
            m_last_next          = (idx_next == CW'(NUM_DIGITS - 1));
            rem_next             = rem_reg << BW;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_digit_address_reg <= m_digit_address_next;
        m_segments_reg      <= m_segments_next;
        m_last_reg          <= m_last_next;
        idx_reg             <= idx_next;
        rem_reg             <= rem_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_digit_address = m_digit_address_reg;
    assign m_segments      = m_segments_reg;
    assign m_last          = m_last_reg;

endmodule

// ===== hw/rtl/ssdf_checker.sv =====
// Port-level checker for the seven-segment formatter and its bind to the top level.
module ssdf_checker #(
    parameter int NUM_DIGITS = 4
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [ssdf_pkg::ADDR_W-1:0]   m_digit_address,
    input logic [ssdf_pkg::SEG_W-1:0]    m_segments,
    input logic                          m_last
);

    localparam int AW = ssdf_pkg::ADDR_W;
    localparam logic [AW-1:0] ADDR_MAX = ssdf_pkg::DIGIT_BASE + AW'(NUM_DIGITS - 1);

    // A stalled write holds its contents
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digit_address)
                                && $stable(m_segments) && $stable(m_last))
        else $error("stalled write changed");

    // Writes only reach the display digit registers
    a_addr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_digit_address >= ssdf_pkg::DIGIT_BASE && m_digit_address <= ADDR_MAX)
        else $error("digit address out of range");

    // Number writes follow without a gap at the next digit position
    a_digit_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=>
            m_valid && m_digit_address == $past(m_digit_address) + AW'(1))
        else $error("number write sequence broken");

    // No new request is taken while a write is stalled
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("request taken during output stall");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("write valid after reset");

endmodule

bind seven_segment_display_formatter ssdf_checker #(.NUM_DIGITS(NUM_DIGITS)) u_ssdf_checker (.*);

// ===== test/seven_segment_display_formatter_test.sv =====
// Self-checking testbench for the seven-segment formatter under random back-pressure.
`timescale 1ns / 1ps

module seven_segment_display_formatter_test;

    localparam logic [5:0] DIGIT_REG_BASE  = 6'h34;
    localparam logic [7:0] CARRIAGE_RETURN = 8'd13;
    localparam logic [7:0] FIRST_GLYPH     = 8'd32;
    localparam logic [7:0] LAST_GLYPH      = 8'd127;
    localparam logic [7:0] DECIMAL_POINT   = 8'h80;
    localparam int         DISPLAY_DIGITS  = 4;
    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         DRAIN_CYCLES    = 20;
    localparam int         MAX_PRINTED     = 40;

    // Segment patterns for codes 32..127
    localparam logic [7:0] GLYPHS [96] = '{
        8'h00, 8'h82, 8'h21, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02,
        8'h39, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h40, 8'h80, 8'h00,
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h48, 8'h00, 8'h53,
        8'h00, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h6F,
        8'h76, 8'h06, 8'h1E, 8'h00, 8'h38, 8'h00, 8'h54, 8'h3F,
        8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h3E, 8'h00, 8'h00,
        8'h00, 8'h6E, 8'h00, 8'h39, 8'h00, 8'h0F, 8'h00, 8'h08,
        8'h63, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F,
        8'h74, 8'h02, 8'h1E, 8'h00, 8'h06, 8'h00, 8'h54, 8'h5C,
        8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h00, 8'h00,
        8'h00, 8'h6E, 8'h00, 8'h39, 8'h30, 8'h0F, 8'h00, 8'h00
    };

    typedef struct packed {
        logic [5:0] address;
        logic [7:0] segments;
        logic       last;
    } digit_write_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic        s_op        = 1'b0;
    logic [7:0]  s_char_code = 8'd0;
    logic        s_dp        = 1'b0;
    logic [15:0] s_number    = 16'd0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [5:0]  m_digit_address;
    logic [7:0]  m_segments;
    logic        m_last;

    digit_write_t expected_writes[$];
    logic [1:0]   text_cursor = 2'd0;
    int           error_count = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           ready_stall_pct = 0;

    seven_segment_display_formatter dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_char_code     (s_char_code),
        .s_dp            (s_dp),
        .s_number        (s_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_digit_address (m_digit_address),
        .m_segments      (m_segments),
        .m_last          (m_last)
    );

    always #5 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Random back-pressure on the write channel
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
    end

    function automatic logic [7:0] glyph_of(input logic [7:0] code);
        logic [7:0] offs;
        offs = code - FIRST_GLYPH;
        if (code < FIRST_GLYPH || code > LAST_GLYPH) begin
            return 8'h00;
        end
        return GLYPHS[offs[6:0]];
    endfunction

    // Expected digit writes for one accepted request; tracks the text cursor
    function automatic void predict_writes(input ssdf_pkg::op_t op, input logic [7:0] code,
                                           input logic dp, input logic [15:0] number);
        digit_write_t wr;
        int unsigned  value;
        int unsigned  place;
        if (op == ssdf_pkg::OP_CHAR) begin
            if (code == CARRIAGE_RETURN) begin
                text_cursor = 2'd0;
                return;
            end
            wr.address  = DIGIT_REG_BASE + {4'd0, text_cursor};
            wr.segments = glyph_of(code) + (dp ? DECIMAL_POINT : 8'h00);
            wr.last     = 1'b1;
            expected_writes.push_back(wr);
            text_cursor = text_cursor + 2'd1;
        end else begin
            value = number % 10000;
            place = 1000;
            for (int i = 0; i < DISPLAY_DIGITS; i++) begin
                wr.address  = DIGIT_REG_BASE + 6'(i);
                wr.segments = glyph_of(8'(8'd48 + (value / place) % 10));
                wr.last     = (i == DISPLAY_DIGITS - 1);
                expected_writes.push_back(wr);
                place = place / 10;
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
    endtask

    // Check each write against the oldest expectation, then predict new requests
    always @(posedge aclk) begin : check_writes
        digit_write_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_writes.size() == 0) begin
                    report_mismatch("write with nothing expected, segments", m_segments, 0);
                end else begin
                    want = expected_writes.pop_front();
                    if (m_digit_address !== want.address)
                        report_mismatch("digit address", m_digit_address, want.address);
                    if (m_segments !== want.segments)
                        report_mismatch("segments", m_segments, want.segments);
                    if (m_last !== want.last)
                        report_mismatch("last", m_last, want.last);
                end
            end
            if (s_valid && s_ready)
                predict_writes(ssdf_pkg::op_t'(s_op), s_char_code, s_dp, s_number);
        end
    end

    // Present one request, with optional idle cycles ahead of it, and wait for it to be taken
    task automatic send_request(input ssdf_pkg::op_t op, input logic [7:0] code,
                                input logic dp, input logic [15:0] number);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_char_code <= code;
        s_dp        <= dp;
        s_number    <= number;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Font edges, blank codes, decimal point wrap and cursor wrap
    task automatic test_character_codes();
        send_request(ssdf_pkg::OP_CHAR, 8'd65,  1'b0, 16'h0000);
        send_request(ssdf_pkg::OP_CHAR, 8'd0,   1'b0, 16'hFFFF);
        send_request(ssdf_pkg::OP_CHAR, 8'd31,  1'b0, 16'h0000);
        send_request(ssdf_pkg::OP_CHAR, 8'd32,  1'b0, 16'hFFFF);
        send_request(ssdf_pkg::OP_CHAR, 8'd127, 1'b1, 16'h0000);
        send_request(ssdf_pkg::OP_CHAR, 8'd128, 1'b0, 16'hFFFF);
        send_request(ssdf_pkg::OP_CHAR, 8'd255, 1'b1, 16'h0000);
        send_request(ssdf_pkg::OP_CHAR, 8'd56,  1'b1, 16'hFFFF);
        send_request(ssdf_pkg::OP_CHAR, 8'd46,  1'b1, 16'h0000);
    endtask

    // Carriage return homes the cursor mid-line and back to back
    task automatic test_cursor_home();
        send_request(ssdf_pkg::OP_CHAR, CARRIAGE_RETURN, 1'b0, 16'h0000);
        send_request(ssdf_pkg::OP_CHAR, 8'd72, 1'b0, 16'h0000);
        send_request(ssdf_pkg::OP_CHAR, 8'd73, 1'b0, 16'h0000);
        send_request(ssdf_pkg::OP_CHAR, CARRIAGE_RETURN, 1'b1, 16'hFFFF);
        send_request(ssdf_pkg::OP_CHAR, CARRIAGE_RETURN, 1'b0, 16'h0000);
        send_request(ssdf_pkg::OP_CHAR, 8'd49, 1'b1, 16'h0000);
    endtask

    // Number mode range, modulo wrap, and fields that must be ignored
    task automatic test_number_range();
        send_request(ssdf_pkg::OP_NUMBER, 8'd0,            1'b0, 16'd0);
        send_request(ssdf_pkg::OP_NUMBER, CARRIAGE_RETURN, 1'b1, 16'd9999);
        send_request(ssdf_pkg::OP_NUMBER, 8'd255,          1'b1, 16'd10000);
        send_request(ssdf_pkg::OP_NUMBER, CARRIAGE_RETURN, 1'b0, 16'd65535);
        send_request(ssdf_pkg::OP_NUMBER, 8'd65,           1'b1, 16'd1234);
        send_request(ssdf_pkg::OP_NUMBER, 8'd0,            1'b0, 16'd12345);
        // cursor must still be where character mode left it
        send_request(ssdf_pkg::OP_CHAR, 8'd55, 1'b0, 16'd0);
    endtask

    // Mixed text lines and numbers with random content
    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int stall_pct);
        int          pick;
        logic [7:0]  code;
        logic [15:0] number;
        send_idle_pct   = send_pct;
        ready_stall_pct = stall_pct;
        repeat (count) begin
            pick   = $urandom_range(0, 99);
            code   = 8'($urandom_range(32, 127));
            number = 16'($urandom);
            if (pick < 45) begin
                send_request(ssdf_pkg::OP_CHAR, code, 1'($urandom), number);
            end else if (pick < 55) begin
                send_request(ssdf_pkg::OP_CHAR, 8'($urandom), 1'($urandom), number);
            end else if (pick < 63) begin
                send_request(ssdf_pkg::OP_CHAR, CARRIAGE_RETURN, 1'($urandom), number);
            end else if (pick < 82) begin
                send_request(ssdf_pkg::OP_NUMBER, 8'($urandom), 1'($urandom),
                             16'($urandom_range(0, 9999)));
            end else begin
                send_request(ssdf_pkg::OP_NUMBER, 8'($urandom), 1'($urandom), number);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_character_codes();
        test_cursor_home();
        test_number_range();
        test_random_traffic(48, 0, 0);
        test_random_traffic(48, 68, 0);
        test_random_traffic(48, 0, 68);
        test_random_traffic(48, 18, 18);
        s_valid <= 1'b0;

        // let the last request's prediction land, drain, then watch for strays
        @(posedge aclk);
        while (expected_writes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_writes.size() != 0)
            report_mismatch("writes never delivered", expected_writes.size(), 0);

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ssdf_pkg.sv
hw/rtl/ssdf_digit_pipe.sv
hw/rtl/seven_segment_display_formatter.sv
hw/rtl/ssdf_checker.sv
test/seven_segment_display_formatter_test.sv
